[hw/rtl/hrcf_pkg.sv]
package hrcf_pkg;

  // Default sizes of the device table and the per-slot report buffer.
  localparam int DEVICE_SLOTS_DEF = 8;
  localparam int REPORT_BYTES_DEF = 64;

  // Widest slot number and byte position over the supported parameter range.
  localparam int SLOT_MAX_W = 6;
  localparam int POS_MAX_W  = 8;

  // Width of the slot field in a result.
  localparam int SLOT_OUT_W = 3;

  // Number of entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One input transfer: a report byte with its device ids.
  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  report_byte;
    logic        byte_last;
  } in_item_t;

  // One result transfer, sent on the last byte of a report.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] device_slot;
    logic                  report_changed;
    logic                  device_new;
    logic                  table_full;
  } out_item_t;

  // A classified byte, handed from the front to the back.
  typedef struct packed {
    logic [SLOT_MAX_W-1:0] slot;
    logic [POS_MAX_W-1:0]  pos;
    logic [7:0]            data;
    logic                  store;
    logic                  last;
    logic                  drop;
    logic                  claim;
  } q_entry_t;

endpackage

[hw/rtl/hrcf_front.sv]
module hrcf_front #(
  parameter int DEVICE_SLOTS = 8,
  parameter int REPORT_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  hrcf_pkg::in_item_t in_item,
  output hrcf_pkg::q_entry_t q_entry
);
  import hrcf_pkg::*;

  localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int USED_W = $clog2(DEVICE_SLOTS + 1);
  localparam int POS_W  = $clog2(REPORT_BYTES + 1);

  // Device table.
  logic        valid_r   [DEVICE_SLOTS];
  logic [15:0] vendor_r  [DEVICE_SLOTS];
  logic [15:0] product_r [DEVICE_SLOTS];
  logic [USED_W-1:0] used_r;

  // Context of the report in progress.
  logic              in_report_r;
  logic [SLOT_W-1:0] slot_r;
  logic              claim_r;
  logic              drop_r;
  logic [POS_W-1:0]  pos_r;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              first;
  logic              has_free;
  logic              do_claim;
  logic [SLOT_W-1:0] slot_cur;
  logic              claim_cur;
  logic              drop_cur;
  logic [POS_W-1:0]  pos_cur;
  logic              store_cur;
  logic [POS_W-1:0]  pos_nxt;

  // Search the valid slots for the ids; the lowest match wins.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = DEVICE_SLOTS - 1; s >= 0; s--) begin
      if (valid_r[s] && vendor_r[s] == in_item.vendor_id &&
          product_r[s] == in_item.product_id) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
    end
  end

  // Classify the byte: matched, newly claimed or dropped slot.
  assign first    = !in_report_r;
  assign has_free = used_r < USED_W'(DEVICE_SLOTS);
  assign do_claim = in_fire && first && !hit && has_free;

  always_comb begin
    if (first) begin
      if (hit) begin
        slot_cur  = hit_slot;
        claim_cur = 1'b0;
        drop_cur  = 1'b0;
      end else if (has_free) begin
        slot_cur  = used_r[SLOT_W-1:0];
        claim_cur = 1'b1;
        drop_cur  = 1'b0;
      end else begin
        slot_cur  = '0;
        claim_cur = 1'b0;
        drop_cur  = 1'b1;
      end
      pos_cur = '0;
    end else begin
      slot_cur  = slot_r;
      claim_cur = claim_r;
      drop_cur  = drop_r;
      pos_cur   = pos_r;
    end
  end

  // Bytes past the buffer are neither compared nor stored.
  assign store_cur = !drop_cur && (pos_cur < POS_W'(REPORT_BYTES));
  assign pos_nxt   = in_item.byte_last ? '0 : pos_cur + POS_W'(store_cur);

  assign q_entry.slot  = SLOT_MAX_W'(slot_cur);
  assign q_entry.pos   = POS_MAX_W'(pos_cur);
  assign q_entry.data  = in_item.report_byte;
  assign q_entry.store = store_cur;
  assign q_entry.last  = in_item.byte_last;
  assign q_entry.drop  = drop_cur;
  assign q_entry.claim = claim_cur;

  // Report context registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_report_r <= 1'b0;
      slot_r      <= '0;
      claim_r     <= 1'b0;
      drop_r      <= 1'b0;
      pos_r       <= '0;
      used_r      <= '0;
    end else if (in_fire) begin
      in_report_r <= !in_item.byte_last;
      slot_r      <= slot_cur;
      claim_r     <= claim_cur;
      drop_r      <= drop_cur;
      pos_r       <= pos_nxt;
      if (do_claim) begin
        used_r <= used_r + USED_W'(1);
      end
    end
  end

  // Table entries: valid bits reset, ids are written when a slot is claimed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEVICE_SLOTS; s++) begin
        valid_r[s] <= 1'b0;
      end
    end else if (do_claim) begin
      valid_r[used_r[SLOT_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_claim) begin
      vendor_r[used_r[SLOT_W-1:0]]  <= in_item.vendor_id;
      product_r[used_r[SLOT_W-1:0]] <= in_item.product_id;
    end
  end

  // A claim takes exactly one free slot.
  a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
    do_claim |=> used_r == $past(used_r) + USED_W'(1))
    else $error("slot claim did not advance the used count");

endmodule

[hw/rtl/hrcf_queue.sv]
module hrcf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hrcf_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               q_valid,
  output logic               q_full,
  output hrcf_pkg::q_entry_t head
);
  import hrcf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign q_valid = count_r != '0;
  assign q_full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

[hw/rtl/hrcf_back.sv]
module hrcf_back #(
  parameter int DEVICE_SLOTS = 8,
  parameter int REPORT_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hrcf_pkg::q_entry_t  head,
  output logic                pop,
  output logic                out_strobe,
  output hrcf_pkg::out_item_t out_item
);
  import hrcf_pkg::*;

  localparam int SLOT_W    = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int POS_W     = $clog2(REPORT_BYTES + 1);
  localparam int MEM_DEPTH = DEVICE_SLOTS * REPORT_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int EXT_W     = SLOT_W + SLOT_OUT_W;

  // Previous reports, one row of bytes per slot.
  logic [7:0] mem [MEM_DEPTH];

  // Per-slot count of bytes ever written; entries past it read as zero.
  logic [POS_W-1:0] fill_r [DEVICE_SLOTS];

  logic [ADDR_W-1:0] head_addr;
  logic              b_v_r;
  q_entry_t          b_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [7:0]        rd_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic              diff_r;
  logic              strobe_r;
  out_item_t         item_r;

  logic [SLOT_W-1:0] b_slot;
  logic [POS_W-1:0]  b_pos;
  logic              wr_en;
  logic              known;
  logic [7:0]        prev_byte;
  logic              cur_diff;
  logic [EXT_W-1:0]  slot_ext;

  // The back never stalls, so it takes the queue head whenever there is one.
  assign pop       = q_valid;
  assign head_addr = ADDR_W'(head.slot[SLOT_W-1:0]) * ADDR_W'(REPORT_BYTES) +
                     ADDR_W'(head.pos[POS_W-1:0]);

  assign b_slot    = b_r.slot[SLOT_W-1:0];
  assign b_pos     = b_r.pos[POS_W-1:0];
  assign wr_en     = b_v_r && b_r.store;
  assign known     = b_pos < fill_r[b_slot];
  assign prev_byte = !known ? 8'h00 : (fwd_r ? fwd_data_r : rd_r);
  assign cur_diff  = b_r.store && (prev_byte != b_r.data);
  assign slot_ext  = EXT_W'(b_slot);

  // Buffer read at issue, write at compare; a write to the address being
  // read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (pop && head.store) begin
      rd_r <= mem[head_addr];
    end
    if (wr_en) begin
      mem[b_addr_r] <= b_r.data;
    end
  end

  // Compare stage payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      b_r        <= head;
      b_addr_r   <= head_addr;
      fwd_r      <= wr_en && (b_addr_r == head_addr);
      fwd_data_r <= b_r.data;
    end
  end

  // Control: stage valid, fill counts and the running difference flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r  <= 1'b0;
      diff_r <= 1'b0;
      for (int s = 0; s < DEVICE_SLOTS; s++) begin
        fill_r[s] <= '0;
      end
    end else begin
      b_v_r <= pop;
      if (b_v_r) begin
        diff_r <= b_r.last ? 1'b0 : (diff_r | cur_diff);
      end
      if (wr_en && !known) begin
        fill_r[b_slot] <= b_pos + POS_W'(1);
      end
    end
  end

  // Result register; a dropped report carries only the full flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= b_v_r && b_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v_r && b_r.last) begin
      if (b_r.drop) begin
        item_r.device_slot    <= '0;
        item_r.report_changed <= 1'b0;
        item_r.device_new     <= 1'b0;
        item_r.table_full     <= 1'b1;
      end else begin
        item_r.device_slot    <= slot_ext[SLOT_OUT_W-1:0];
        item_r.report_changed <= diff_r | cur_diff;
        item_r.device_new     <= b_r.claim;
        item_r.table_full     <= 1'b0;
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.table_full) |->
      (out_item.device_slot == '0 && !out_item.report_changed && !out_item.device_new))
    else $error("dropped report carries slot data");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && b_r.last) |=> out_strobe)
    else $error("last byte produced no result");

endmodule

[hw/rtl/hid_report_change_filter.sv]
// Change filter for HID input reports, one report byte per transfer.
// Input channel: a transfer is taken at a clock edge with start high and busy
// low. in_item carries the device ids, the byte and a last-byte mark; the ids
// count only on the first byte of a report.
// Result channel: out_strobe is high for one cycle per finished report and
// out_item then gives the slot, the changed flag, the new-device flag and the
// table-full flag. The receiver cannot stall, so results are never held.
// Path: the last byte passes the queue, then the buffer read/compare/write
// stage, then the result register.
// Throughput: one byte per cycle; the back drains the queue every cycle, so
// busy only rises if the queue is full, which this back never lets happen.
// Reset (rst_n low, synchronous) empties the device table and marks every
// stored report as all zero through per-slot fill counts; no clearing pass
// is needed and the block takes a byte in the first cycle after reset.
module hid_report_change_filter #(
  parameter int DEVICE_SLOTS = hrcf_pkg::DEVICE_SLOTS_DEF,
  parameter int REPORT_BYTES = hrcf_pkg::REPORT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hrcf_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output hrcf_pkg::out_item_t out_item
);
  import hrcf_pkg::*;

  logic     in_fire;
  q_entry_t push_entry;
  q_entry_t head;
  logic     q_valid;
  logic     q_full;
  logic     pop;

  assign busy    = q_full;
  assign in_fire = start && !busy;

  // Front: table search, slot claim and byte classification.
  hrcf_front #(
    .DEVICE_SLOTS (DEVICE_SLOTS),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .q_entry (push_entry)
  );

  // Queue between the two halves.
  hrcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  // Back: buffer compare and write, result generation.
  hrcf_back #(
    .DEVICE_SLOTS (DEVICE_SLOTS),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
